[hw/rtl/brhf_pkg.sv]
// Shared types and constants for the bilinear resample / hole fill block.
// No dependencies; imported by every module of the block.
package brhf_pkg;

    // Fixed field widths
    localparam int SRC_W  = 12;   // one-based source number
    localparam int FRAC_W = 12;   // fractional offset inputs
    localparam int PIX_W  = 16;   // neighbour pixels, signed
    localparam int WIN_W  = 11;   // pass window bounds
    localparam int VAL_W  = 15;   // output pixel value

    // Highest one-based source number that can be resampled
    localparam int MAX_SOURCES = 2048;

    // Saturation limit of the output value
    localparam logic [VAL_W-1:0] PIX_MAX = 15'd32766;

    // Configuration register indexes
    localparam logic [1:0] CFG_INTERP    = 2'd0;
    localparam logic [1:0] CFG_WIN_FIRST = 2'd1;
    localparam logic [1:0] CFG_WIN_LAST  = 2'd2;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic             write;     // pixel passed all qualification checks
        logic             interp;    // bilinear blend, else nearest neighbour
        logic [VAL_W-1:0] near_val;  // clamped nearest-neighbour value
    } brhf_ctl_t;

endpackage

[hw/rtl/bilinear_resample_hole_fill_top.sv]
// Top level of the bilinear resample / hole fill block: configuration
// registers, pipeline valid and flow control, output register.
// Depends on brhf_pkg, brhf_front and brhf_blend.
//
//  channel | signals                         | transfer when
//  --------+---------------------------------+---------------------------
//  in      | in_valid, in_stall, item fields | in_valid && !in_stall
//  out     | out_valid, out_stall, results   | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, idx, data | cfg_valid && cfg_ready
//
// One pixel per clock while out_stall is low. The stage 1 register loads at
// the input transfer, and out_valid follows through three blend stages (row
// products, row sums, column products) and then the output register.
// Reset clears all valid bits and loads the register defaults
// (bilinear mode, window 0..2047); the block takes items right after.
// Each stage holds when the stage after it is full and held, so bubbles
// close up under out_stall and in_stall only rises when every stage is full.
module bilinear_resample_hole_fill_top
    import brhf_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [WIN_W-1:0]        cfg_data,
    // input items
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SRC_W-1:0]        source_index,
    input  logic                    source_present,
    input  logic                    already_set,
    input  logic [FRAC_W-1:0]       frac_samp,
    input  logic [FRAC_W-1:0]       frac_line,
    input  logic signed [PIX_W-1:0] pix_ul,
    input  logic signed [PIX_W-1:0] pix_ur,
    input  logic signed [PIX_W-1:0] pix_ll,
    input  logic signed [PIX_W-1:0] pix_lr,
    // result items
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    write_pixel,
    output logic [VAL_W-1:0]        pixel_value
);

    logic                    interp_enable_reg;
    logic [WIN_W-1:0]        window_first_reg;
    logic [WIN_W-1:0]        window_last_reg;

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    v4_reg;
    logic                    out_valid_reg;
    logic                    rdy1;
    logic                    rdy2;
    logic                    rdy3;
    logic                    rdy4;
    logic                    rdy_out;

    brhf_ctl_t               ctl1;
    brhf_ctl_t               ctl2_reg;
    brhf_ctl_t               ctl3_reg;
    brhf_ctl_t               ctl4_reg;

    logic signed [PIX_W-1:0] ul1;
    logic signed [PIX_W-1:0] ur1;
    logic signed [PIX_W-1:0] ll1;
    logic signed [PIX_W-1:0] lr1;
    logic [FRAC_BITS:0]      wl1;
    logic [FRAC_BITS:0]      wr1;
    logic [FRAC_BITS:0]      wt1;
    logic [FRAC_BITS:0]      wb1;
    logic [VAL_W-1:0]        blend_val;

    logic                    write_pixel_reg;
    logic [VAL_W-1:0]        pixel_value_reg;
    logic [VAL_W-1:0]        pixel_value_next;

    // Configuration registers; writes always complete
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_enable_reg <= 1'b1;
            window_first_reg  <= '0;
            window_last_reg   <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INTERP:    interp_enable_reg <= cfg_data[0];
                CFG_WIN_FIRST: window_first_reg  <= cfg_data;
                CFG_WIN_LAST:  window_last_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Flow control: a stage loads when it is empty or the next one moves
    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy_out)
                out_valid_reg <= v4_reg;
        end
    end

    // Stage 1: qualify, fill, weights
    brhf_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .en             (rdy1),
        .interp_enable  (interp_enable_reg),
        .window_first   (window_first_reg),
        .window_last    (window_last_reg),
        .source_index   (source_index),
        .source_present (source_present),
        .already_set    (already_set),
        .frac_samp      (frac_samp),
        .frac_line      (frac_line),
        .pix_ul         (pix_ul),
        .pix_ur         (pix_ur),
        .pix_ll         (pix_ll),
        .pix_lr         (pix_lr),
        .ctl_reg        (ctl1),
        .ul_reg         (ul1),
        .ur_reg         (ur1),
        .ll_reg         (ll1),
        .lr_reg         (lr1),
        .wl_reg         (wl1),
        .wr_reg         (wr1),
        .wt_reg         (wt1),
        .wb_reg         (wb1)
    );

    // Stages 2 to 4: bilinear blend
    brhf_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk   (clk),
        .en2   (rdy2),
        .en3   (rdy3),
        .en4   (rdy4),
        .ul    (ul1),
        .ur    (ur1),
        .ll    (ll1),
        .lr    (lr1),
        .wl    (wl1),
        .wr    (wr1),
        .wt    (wt1),
        .wb    (wb1),
        .value (blend_val)
    );

    // Carry the control word alongside the blend stages
    always_ff @(posedge clk)
    begin
        if (rdy2)
            ctl2_reg <= ctl1;
        if (rdy3)
            ctl3_reg <= ctl2_reg;
        if (rdy4)
            ctl4_reg <= ctl3_reg;
    end

    // Select the result value; skipped pixels give zero
    always_comb
    begin
        if (!ctl4_reg.write)
            pixel_value_next = '0;
        else if (ctl4_reg.interp)
            pixel_value_next = blend_val;
        else
            pixel_value_next = ctl4_reg.near_val;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            write_pixel_reg <= ctl4_reg.write;
            pixel_value_reg <= pixel_value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_pixel = write_pixel_reg;
    assign pixel_value = pixel_value_reg;

endmodule

[hw/rtl/brhf_front.sv]
// Front stage: qualify the pixel, fill zero neighbours, pick the nearest
// neighbour and form the blend weights. Ends in the first pipeline register.
// Depends on brhf_pkg.
module brhf_front
    import brhf_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          en,
    // configuration
    input  logic                          interp_enable,
    input  logic [WIN_W-1:0]              window_first,
    input  logic [WIN_W-1:0]              window_last,
    // input item
    input  logic [SRC_W-1:0]              source_index,
    input  logic                          source_present,
    input  logic                          already_set,
    input  logic [FRAC_W-1:0]             frac_samp,
    input  logic [FRAC_W-1:0]             frac_line,
    input  logic signed [PIX_W-1:0]       pix_ul,
    input  logic signed [PIX_W-1:0]       pix_ur,
    input  logic signed [PIX_W-1:0]       pix_ll,
    input  logic signed [PIX_W-1:0]       pix_lr,
    // first stage register
    output brhf_ctl_t                     ctl_reg,
    output logic signed [PIX_W-1:0]       ul_reg,
    output logic signed [PIX_W-1:0]       ur_reg,
    output logic signed [PIX_W-1:0]       ll_reg,
    output logic signed [PIX_W-1:0]       lr_reg,
    output logic [FRAC_BITS:0]            wl_reg,
    output logic [FRAC_BITS:0]            wr_reg,
    output logic [FRAC_BITS:0]            wt_reg,
    output logic [FRAC_BITS:0]            wb_reg
);

    localparam int WW = FRAC_BITS + 1;
    localparam logic [31:0]   FMASK = (32'd1 << FRAC_BITS) - 32'd1;
    localparam logic [31:0]   HALF  = 32'd1 << (FRAC_BITS - 1);
    localparam logic [WW-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};

    logic [31:0]             fs32;
    logic [31:0]             fl32;
    logic [SRC_W-1:0]        k;
    logic                    skip;
    logic                    right;
    logic                    lower;
    logic signed [PIX_W-1:0] near_raw;
    logic signed [PIX_W-1:0] ul_f;
    logic signed [PIX_W-1:0] ur_f;
    logic signed [PIX_W-1:0] ll_f;
    logic signed [PIX_W-1:0] lr_f;
    brhf_ctl_t               ctl_next;

    // Drop fraction bits at or above the binary point
    assign fs32 = {{(32-FRAC_W){1'b0}}, frac_samp} & FMASK;
    assign fl32 = {{(32-FRAC_W){1'b0}}, frac_line} & FMASK;

    // Qualify against already set, presence, capacity and the pass window
    assign k = source_index - {{(SRC_W-1){1'b0}}, 1'b1};
    assign skip = already_set || !source_present
               || (source_index == '0)
               || ({{(32-SRC_W){1'b0}}, source_index} > 32'(MAX_SOURCES))
               || (k < {1'b0, window_first})
               || (k > {1'b0, window_last});

    // Pick the neighbour nearest to the position and clamp it
    assign right    = fs32 >= HALF;
    assign lower    = fl32 >= HALF;
    assign near_raw = lower ? (right ? pix_lr : pix_ll) : (right ? pix_ur : pix_ul);

    always_comb
    begin
        ctl_next.write  = !skip;
        ctl_next.interp = interp_enable;
        if (near_raw[PIX_W-1])
            ctl_next.near_val = '0;
        else if (near_raw[VAL_W-1:0] > PIX_MAX)
            ctl_next.near_val = PIX_MAX;
        else
            ctl_next.near_val = near_raw[VAL_W-1:0];
    end

    // Fill zero neighbours: upper left first, the others from it, lr from ur_f
    always_comb
    begin
        if (pix_ul != '0)
            ul_f = pix_ul;
        else if (pix_ur != '0)
            ul_f = pix_ur;
        else if (pix_ll != '0)
            ul_f = pix_ll;
        else
            ul_f = pix_lr;
        ur_f = (pix_ur != '0) ? pix_ur : ul_f;
        ll_f = (pix_ll != '0) ? pix_ll : ul_f;
        lr_f = (pix_lr != '0) ? pix_lr : ur_f;
    end

    // Stage 1 register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= ctl_next;
            ul_reg  <= ul_f;
            ur_reg  <= ur_f;
            ll_reg  <= ll_f;
            lr_reg  <= lr_f;
            wr_reg  <= fs32[WW-1:0];
            wl_reg  <= ONE - fs32[WW-1:0];
            wb_reg  <= fl32[WW-1:0];
            wt_reg  <= ONE - fl32[WW-1:0];
        end
    end

endmodule

[hw/rtl/brhf_blend.sv]
// Bilinear blend datapath: row products, row sums, column products, then
// the final sum with clamp and round. Depends on brhf_pkg.
module brhf_blend
    import brhf_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    en2,
    input  logic                    en3,
    input  logic                    en4,
    input  logic signed [PIX_W-1:0] ul,
    input  logic signed [PIX_W-1:0] ur,
    input  logic signed [PIX_W-1:0] ll,
    input  logic signed [PIX_W-1:0] lr,
    input  logic [FRAC_BITS:0]      wl,
    input  logic [FRAC_BITS:0]      wr,
    input  logic [FRAC_BITS:0]      wt,
    input  logic [FRAC_BITS:0]      wb,
    output logic [VAL_W-1:0]        value
);

    localparam int WW = FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 17;
    localparam int AW = 2 * FRAC_BITS + 18;
    localparam int SH = 2 * FRAC_BITS;
    localparam logic signed [AW-1:0] LIM = AW'(32766) <<< SH;
    localparam logic signed [AW-1:0] RND = AW'(1) <<< (SH - 1);

    logic signed [PW-1:0] p_ul_reg;
    logic signed [PW-1:0] p_ur_reg;
    logic signed [PW-1:0] p_ll_reg;
    logic signed [PW-1:0] p_lr_reg;
    logic [WW-1:0]        wt2_reg;
    logic [WW-1:0]        wb2_reg;
    logic signed [PW-1:0] top_reg;
    logic signed [PW-1:0] bot_reg;
    logic [WW-1:0]        wt3_reg;
    logic [WW-1:0]        wb3_reg;
    logic signed [AW-1:0] q_top_reg;
    logic signed [AW-1:0] q_bot_reg;

    logic signed [PW-1:0] wl_x;
    logic signed [PW-1:0] wr_x;
    logic signed [PW-1:0] ul_x;
    logic signed [PW-1:0] ur_x;
    logic signed [PW-1:0] ll_x;
    logic signed [PW-1:0] lr_x;
    logic signed [AW-1:0] wt_x;
    logic signed [AW-1:0] wb_x;
    logic signed [AW-1:0] top_x;
    logic signed [AW-1:0] bot_x;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] acc_rnd;

    // Widen operands so each product is formed at its full width
    assign wl_x  = PW'($signed({1'b0, wl}));
    assign wr_x  = PW'($signed({1'b0, wr}));
    assign ul_x  = PW'(ul);
    assign ur_x  = PW'(ur);
    assign ll_x  = PW'(ll);
    assign lr_x  = PW'(lr);
    assign wt_x  = AW'($signed({1'b0, wt3_reg}));
    assign wb_x  = AW'($signed({1'b0, wb3_reg}));
    assign top_x = AW'(top_reg);
    assign bot_x = AW'(bot_reg);

    // Stage 2: horizontal weight times pixel
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            p_ul_reg <= wl_x * ul_x;
            p_ur_reg <= wr_x * ur_x;
            p_ll_reg <= wl_x * ll_x;
            p_lr_reg <= wr_x * lr_x;
            wt2_reg  <= wt;
            wb2_reg  <= wb;
        end
    end

    // Stage 3: upper and lower row sums
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            top_reg <= p_ul_reg + p_ur_reg;
            bot_reg <= p_ll_reg + p_lr_reg;
            wt3_reg <= wt2_reg;
            wb3_reg <= wb2_reg;
        end
    end

    // Stage 4: vertical weight times row sum
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            q_top_reg <= wt_x * top_x;
            q_bot_reg <= wb_x * bot_x;
        end
    end

    // Sum, clamp to the output range and round half up
    assign acc     = q_top_reg + q_bot_reg;
    assign acc_rnd = acc + RND;

    always_comb
    begin
        if (acc <= 0)
            value = '0;
        else if (acc > LIM)
            value = PIX_MAX;
        else
            value = acc_rnd[SH+VAL_W-1:SH];
    end

endmodule

[test/tb_bilinear_resample_hole_fill_top.sv]
`timescale 1ns / 1ps
// Testbench for bilinear_resample_hole_fill_top: directed and random pixels
// go through a queue-fed driver, and a monitor checks results against a predictor.
// Depends on brhf_pkg and the block's RTL.
module tb_bilinear_resample_hole_fill_top;
    import brhf_pkg::*;

    localparam int     FRAC         = 12;
    localparam longint ONE          = longint'(1) << FRAC;
    localparam longint HALF         = longint'(1) << (FRAC - 1);
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     LONG_HOLD    = 300;

    typedef struct packed {
        logic [SRC_W-1:0]  src;
        logic              present;
        logic              already;
        logic [FRAC_W-1:0] fs;
        logic [FRAC_W-1:0] fl;
        logic [PIX_W-1:0]  ul;
        logic [PIX_W-1:0]  ur;
        logic [PIX_W-1:0]  ll;
        logic [PIX_W-1:0]  lr;
    } pixel_req_t;

    typedef struct packed {
        logic             wr;
        logic [VAL_W-1:0] val;
    } pixel_res_t;

    // Clock, reset and block ports
    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index   = CFG_INTERP;
    logic [WIN_W-1:0] cfg_data    = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic             write_pixel;
    logic [VAL_W-1:0] pixel_value;
    pixel_req_t       cur_req     = '0;

    // Register copy used for prediction, reset values
    logic             mode_interp = 1'b1;
    logic [WIN_W-1:0] win_lo      = '0;
    logic [WIN_W-1:0] win_hi      = '1;

    pixel_req_t pending_pixels[$];
    pixel_res_t expected_pixels[$];
    pixel_res_t want_px;

    int queued_cnt = 0;
    int sent_cnt   = 0;
    int got_cnt    = 0;
    int err_cnt    = 0;
    int cycle_cnt  = 0;

    // Idling controls
    logic tx_idle_on      = 1'b0;
    logic rx_idle_on      = 1'b0;
    logic long_hold_arm   = 1'b0;
    logic long_hold_done  = 1'b0;
    int   long_hold_left  = 0;
    int   tx_gap          = 0;
    int   rx_gap          = 0;

    always #5 clk = ~clk;

    bilinear_resample_hole_fill_top #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_index  (cur_req.src),
        .source_present(cur_req.present),
        .already_set   (cur_req.already),
        .frac_samp     (cur_req.fs),
        .frac_line     (cur_req.fl),
        .pix_ul        (cur_req.ul),
        .pix_ur        (cur_req.ur),
        .pix_ll        (cur_req.ll),
        .pix_lr        (cur_req.lr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_pixel   (write_pixel),
        .pixel_value   (pixel_value)
    );

    // Work out the written flag and value of one pixel under the current registers
    function automatic pixel_res_t resample_pixel(input pixel_req_t r);
        pixel_res_t res;
        int         k;
        longint     ul, ur, ll, lr, fs, fl, top_sum, bot_sum, acc, tmp, near_v;
        res.wr  = 1'b0;
        res.val = '0;
        if (r.already || !r.present)
            return res;
        if (r.src == 0 || int'(r.src) > MAX_SOURCES)
            return res;
        k = int'(r.src) - 1;
        if (k < int'(win_lo) || k > int'(win_hi))
            return res;
        fs = longint'(r.fs) & (ONE - 1);
        fl = longint'(r.fl) & (ONE - 1);
        ul = longint'($signed(r.ul));
        ur = longint'($signed(r.ur));
        ll = longint'($signed(r.ll));
        lr = longint'($signed(r.lr));
        if (mode_interp) begin
            // Fill holes: upper left first, the rest from it, lower right from ur
            if (ul == 0) begin
                if (ur != 0)
                    ul = ur;
                else if (ll != 0)
                    ul = ll;
                else
                    ul = lr;
            end
            if (ur == 0)
                ur = ul;
            if (ll == 0)
                ll = ul;
            if (lr == 0)
                lr = ur;
            top_sum = (ONE - fs) * ul + fs * ur;
            bot_sum = (ONE - fs) * ll + fs * lr;
            acc     = (ONE - fl) * top_sum + fl * bot_sum;
            if (acc <= 0)
                tmp = 0;
            else if (acc > (longint'(PIX_MAX) << (2 * FRAC)))
                tmp = longint'(PIX_MAX);
            else
                tmp = (acc + (longint'(1) << (2 * FRAC - 1))) >>> (2 * FRAC);
            res.val = tmp[VAL_W-1:0];
        end
        else begin
            if (fl >= HALF)
                near_v = (fs >= HALF) ? lr : ll;
            else
                near_v = (fs >= HALF) ? ur : ul;
            if (near_v < 0)
                near_v = 0;
            if (near_v > longint'(PIX_MAX))
                near_v = longint'(PIX_MAX);
            res.val = near_v[VAL_W-1:0];
        end
        res.wr = 1'b1;
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pix();
        case ($urandom_range(0, 9)) inside
            0, 1:    return '0;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4, 5:    return PIX_W'($urandom_range(0, 65535));
            6:       return PIX_W'($urandom_range(1, 255));
            default: return PIX_W'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] pick_frac();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return FRAC_W'(HALF - 1);
            3:       return FRAC_W'(HALF);
            default: return FRAC_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR at result %0d: %s", got_cnt, msg);
    endtask

    task automatic queue_pixel(input logic [SRC_W-1:0] src, input logic present,
                               input logic already, input logic [FRAC_W-1:0] fs,
                               input logic [FRAC_W-1:0] fl, input logic [PIX_W-1:0] ul,
                               input logic [PIX_W-1:0] ur, input logic [PIX_W-1:0] ll,
                               input logic [PIX_W-1:0] lr);
        pixel_req_t r;
        r = '{src, present, already, fs, fl, ul, ur, ll, lr};
        pending_pixels.push_back(r);
        queued_cnt++;
    endtask

    // Queue random pixels, source numbers mostly around the current window
    task automatic queue_random(input int n);
        logic [SRC_W-1:0] src;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       src = SRC_W'($urandom_range(0, 4095));
                1:       src = '0;
                2:       src = SRC_W'($urandom_range(MAX_SOURCES, MAX_SOURCES + 1));
                3:       src = '1;
                default:
                    if (win_lo <= win_hi)
                        src = SRC_W'($urandom_range(int'(win_lo), int'(win_hi) + 2));
                    else
                        src = SRC_W'($urandom_range(0, MAX_SOURCES + 1));
            endcase
            queue_pixel(src, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
                        pick_frac(), pick_frac(), pick_pix(), pick_pix(), pick_pix(),
                        pick_pix());
        end
    endtask

    // Write one register and track it in the predictor's copy
    task automatic set_reg(input logic [1:0] idx, input logic [WIN_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INTERP:    mode_interp = data[0];
            CFG_WIN_FIRST: win_lo = data;
            CFG_WIN_LAST:  win_hi = data;
            default:       ;
        endcase
    endtask

    task automatic set_idling(input logic tx, input logic rx);
        @(posedge clk);
        tx_idle_on <= tx;
        rx_idle_on <= rx;
    endtask

    // Hold until every queued pixel is sent and its result is back, then settle
    task automatic wait_drained();
        while (sent_cnt != queued_cnt || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: present queued pixels, hold while stalled, insert random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                expected_pixels.push_back(resample_pixel(cur_req));
                sent_cnt++;
            end
            if (!(in_valid && in_stall)) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_idle_on && $urandom_range(0, 7) == 0) begin
                    tx_gap   <= $urandom_range(0, 18);
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0) begin
                    cur_req  <= pending_pixels.pop_front();
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk) begin
        if (long_hold_arm && !long_hold_done) begin
            long_hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
        end
    end

    // Monitor: check each result transfer, then pick the next stall value
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_gap    <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    flag_error($sformatf("unexpected result write_pixel=%0b pixel_value=%0d",
                                         write_pixel, pixel_value));
                end
                else begin
                    want_px = expected_pixels.pop_front();
                    if (write_pixel !== want_px.wr)
                        flag_error($sformatf("write_pixel expected %0b got %0b",
                                             want_px.wr, write_pixel));
                    if (pixel_value !== want_px.val)
                        flag_error($sformatf("pixel_value expected %0d got %0d",
                                             want_px.val, pixel_value));
                end
                got_cnt++;
            end
            if (long_hold_left != 0) begin
                out_stall <= 1'b1;
            end
            else if (rx_gap != 0) begin
                rx_gap    <= rx_gap - 1;
                out_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                rx_gap    <= $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("bilinear_resample_hole_fill_top test failed");
            $finish;
        end
    end

    initial begin
        int lo;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: bilinear, full window. Extremes, skips, hole filling.
        set_idling(1'b1, 1'b1);
        queue_pixel(1, 1, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_pixel(1, 1, 0, '1, '1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_pixel(MAX_SOURCES, 1, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_pixel(0, 1, 0, 100, 100, 16'd500, 16'd500, 16'd500, 16'd500);
        queue_pixel(MAX_SOURCES + 1, 1, 0, 100, 100, 16'd500, 16'd500, 16'd500, 16'd500);
        queue_pixel('1, 1, 0, 100, 100, 16'd500, 16'd500, 16'd500, 16'd500);
        queue_pixel(7, 1, 1, 100, 100, 16'd500, 16'd500, 16'd500, 16'd500);
        queue_pixel(7, 0, 0, 100, 100, 16'd500, 16'd500, 16'd500, 16'd500);
        queue_pixel(9, 1, 0, 1000, 3000, 16'd0, 16'd100, 16'd200, 16'd300);
        queue_pixel(9, 1, 0, 1000, 3000, 16'd0, 16'd0, 16'd500, 16'd700);
        queue_pixel(9, 1, 0, 1000, 3000, 16'd0, 16'd0, 16'd0, 16'd900);
        queue_pixel(9, 1, 0, 2500, 700, 16'd50, 16'd0, 16'd0, 16'd0);
        queue_pixel(9, 1, 0, 2500, 700, 16'd10, 16'd20, 16'd30, 16'd0);
        queue_pixel(3, 1, 0, HALF, 0, 16'd1, 16'd2, 16'd1, 16'd2);
        queue_pixel(3, 1, 0, HALF - 1, 0, 16'd1, 16'd2, 16'd1, 16'd2);
        queue_pixel(3, 1, 0, HALF, HALF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        queue_pixel(3, 1, 0, '1, '1, 16'd1000, 16'd2000, 16'd2000, 16'd2000);
        queue_pixel(3, 1, 0, 0, 0, 16'd32766, 16'd32766, 16'd32766, 16'd32766);
        queue_pixel(3, 1, 0, 0, 0, 16'd1, 16'd1, 16'd1, 16'd1);
        wait_drained();

        // Nearest neighbour: the half-way points of both offsets, then random
        set_reg(CFG_INTERP, 0);
        queue_pixel(5, 1, 0, HALF - 1, HALF - 1, 16'd11, 16'd22, 16'd33, 16'd44);
        queue_pixel(5, 1, 0, HALF, HALF - 1, 16'd11, 16'd22, 16'd33, 16'd44);
        queue_pixel(5, 1, 0, HALF - 1, HALF, 16'd11, 16'd22, 16'd33, 16'd44);
        queue_pixel(5, 1, 0, HALF, HALF, 16'd11, 16'd22, 16'd33, 16'd44);
        queue_pixel(5, 1, 0, 0, '1, 16'd11, 16'd22, 16'h8000, 16'd44);
        queue_pixel(5, 1, 0, '1, 0, 16'd11, 16'h7FFF, 16'd33, 16'd44);
        queue_pixel(5, 1, 0, 0, 0, 16'd0, 16'd22, 16'd33, 16'd44);
        queue_random(100);
        wait_drained();

        // Single-entry window at the top of the range
        set_idling(1'b1, 1'b0);
        set_reg(CFG_INTERP, 1);
        set_reg(CFG_WIN_FIRST, '1);
        set_reg(CFG_WIN_LAST, '1);
        queue_random(80);
        wait_drained();

        // Empty window: everything skipped
        set_idling(1'b0, 1'b1);
        set_reg(CFG_WIN_LAST, 0);
        queue_random(40);
        wait_drained();

        // Full window; receiver holds off long enough to back up the pipeline
        set_reg(CFG_WIN_FIRST, 0);
        set_reg(CFG_WIN_LAST, '1);
        queue_random(200);
        long_hold_arm <= 1'b1;
        wait_drained();

        // Random window in nearest mode
        set_idling(1'b1, 1'b1);
        lo = $urandom_range(0, 1000);
        set_reg(CFG_INTERP, 0);
        set_reg(CFG_WIN_FIRST, lo);
        set_reg(CFG_WIN_LAST, lo + $urandom_range(0, 1000));
        queue_random(100);
        wait_drained();

        // Closing stretch at full rate, no idling on either side
        set_idling(1'b0, 1'b0);
        set_reg(CFG_INTERP, 1);
        set_reg(CFG_WIN_FIRST, 3);
        set_reg(CFG_WIN_LAST, 1500);
        queue_random(130);
        wait_drained();

        if (err_cnt == 0)
            $display("bilinear_resample_hole_fill_top test passed");
        else
            $display("bilinear_resample_hole_fill_top test failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/brhf_pkg.sv
hw/rtl/brhf_front.sv
hw/rtl/brhf_blend.sv
hw/rtl/bilinear_resample_hole_fill_top.sv
test/tb_bilinear_resample_hole_fill_top.sv
